// ===== rtl/assert_macros.svh =====
// Assertion macros used by the filter queue RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property while reset is released.
`define HTF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property at every edge, reset included.
`define HTF_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTF_ASSERT(lbl, clk, rstn, prop, msg)
`define HTF_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/htf_pkg.sv =====
`default_nettype none
package htf_pkg;

    // Window and queue sizing
    localparam int WINDOW_BYTES = 16;
    localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
    localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);
    localparam int PRS_BYTES    = WINDOW_BYTES - 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PAT_BYTES    = 9;
    localparam int NUM_ENTS     = 13;
    localparam int NUM_OPENERS  = 4;

    localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

    // Skipped section codes
    localparam logic [2:0] SKIP_NONE = 3'd0;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    typedef logic [7:0] byte_t;
    typedef byte_t [WINDOW_BYTES-1:0] win_t;
    typedef byte_t [PRS_BYTES-1:0] prs_t;
    typedef logic [8*PAT_BYTES-1:0] pat_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_TOKEN,
        F_N_WS,
        F_N_SIGN,
        F_N_PFX,
        F_N_DIG
    } front_state_t;

    typedef enum logic [1:0] {
        PH_NL,
        PH_C0,
        PH_C1,
        PH_END
    } back_phase_t;

    // One decoded token: optional conditional newline, up to two characters
    typedef struct packed {
        logic       nl;
        logic [1:0] n_chars;
        byte_t      c0;
        byte_t      c1;
        logic       step_end;
        logic       doc_end;
    } op_t;

    function automatic byte_t lower8(input byte_t c);
        return (c >= "A" && c <= "Z") ? byte_t'(c + 8'd32) : c;
    endfunction

    // Valid flag and value of a hex digit
    function automatic logic [4:0] hex_val(input byte_t c);
        byte_t lc;
        lc = lower8(c);
        if (c >= "0" && c <= "9") return {1'b1, 4'(c - 8'h30)};
        else if (lc >= "a" && lc <= "f") return {1'b1, 4'(lc - 8'h57)};
        else return 5'd0;
    endfunction

    // Character k of a right-justified pattern of len characters
    function automatic byte_t pat_char(input pat_t p, input logic [3:0] len,
                                       input logic [3:0] k);
        if (k < len) return p[(int'(len) - int'(k) - 1) * 8 +: 8];
        else return CH_NUL;
    endfunction

    function automatic logic pat_hit(input win_t w, input pat_t p, input logic [3:0] len);
        logic hit;
        hit = 1'b1;
        for (int k = 0; k < PAT_BYTES; k++) begin
            if (4'(k) < len && w[k] != pat_char(p, len, 4'(k))) hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic pat_t open_pat(input logic [1:0] i);
        case (i)
            2'd0:    return pat_t'("<head");
            2'd1:    return pat_t'("<style");
            2'd2:    return pat_t'("<script");
            default: return pat_t'("<svg");
        endcase
    endfunction

    function automatic logic [3:0] open_len(input logic [1:0] i);
        case (i)
            2'd0:    return 4'd5;
            2'd1:    return 4'd6;
            2'd2:    return 4'd7;
            default: return 4'd4;
        endcase
    endfunction

    function automatic pat_t close_pat(input logic [1:0] i);
        case (i)
            2'd0:    return pat_t'("</head>");
            2'd1:    return pat_t'("</style>");
            2'd2:    return pat_t'("</script>");
            default: return pat_t'("</svg>");
        endcase
    endfunction

    function automatic logic [3:0] close_len(input logic [1:0] i);
        case (i)
            2'd0:    return 4'd7;
            2'd1:    return 4'd8;
            2'd2:    return 4'd9;
            default: return 4'd6;
        endcase
    endfunction

    function automatic pat_t ent_pat(input logic [3:0] i);
        case (i)
            4'd0:    return pat_t'("&quot;");
            4'd1:    return pat_t'("&apos;");
            4'd2:    return pat_t'("&lsquo;");
            4'd3:    return pat_t'("&rsquo;");
            4'd4:    return pat_t'("&ldquo;");
            4'd5:    return pat_t'("&rdquo;");
            4'd6:    return pat_t'("&mdash;");
            4'd7:    return pat_t'("&ndash;");
            4'd8:    return pat_t'("&hellip;");
            4'd9:    return pat_t'("&amp;");
            4'd10:   return pat_t'("&lt;");
            4'd11:   return pat_t'("&gt;");
            default: return pat_t'("&nbsp;");
        endcase
    endfunction

    function automatic logic [3:0] ent_len(input logic [3:0] i);
        case (i)
            4'd0, 4'd1, 4'd12:                     return 4'd6;
            4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7:    return 4'd7;
            4'd8:                                  return 4'd8;
            4'd9:                                  return 4'd5;
            default:                               return 4'd4;
        endcase
    endfunction

    function automatic byte_t ent_chr(input logic [3:0] i);
        case (i)
            4'd0, 4'd4, 4'd5: return CH_DQUOTE;
            4'd1, 4'd2, 4'd3: return CH_SQUOTE;
            4'd6, 4'd7:       return CH_DASH;
            4'd8:             return ".";
            4'd9:             return "&";
            4'd10:            return "<";
            4'd11:            return ">";
            default:          return CH_SP;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/htf_front.sv =====
`default_nettype none
module htf_front import htf_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  logic  [7:0] s_in_byte,
    input  logic  s_in_last,
    output logic  q_push,
    output op_t   q_data,
    input  logic  q_full
);

    front_state_t      state_reg, state_next;
    win_t              win_reg, win_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              inside_tag_reg, inside_tag_next;
    logic              prev_blank_reg, prev_blank_next;
    logic [2:0]        skip_sec_reg, skip_sec_next;
    logic [3:0]        skip_pos_reg, skip_pos_next;
    logic              finished_reg, finished_next;
    logic              flush_reg, flush_next;
    prs_t              prs_reg, prs_next;
    logic              hex_reg, hex_next;
    logic              neg_reg, neg_next;
    logic [15:0]       acc_reg, acc_next;
    logic              big_reg, big_next;
    logic [3:0]        semi_reg, semi_next;

    // Masked and lowered view of the window
    win_t win_a, win_l;
    always_comb begin
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            win_a[i] = (FILL_W'(i) < fill_reg) ? win_reg[i] : CH_NUL;
            win_l[i] = lower8(win_a[i]);
        end
    end

    // Find the entity terminator in the first ten bytes
    logic [3:0] tok_semi;
    logic       semi_stop;
    always_comb begin
        tok_semi  = 4'd0;
        semi_stop = 1'b0;
        for (int i = 1; i < 10; i++) begin
            if (!semi_stop) begin
                if (win_a[i] == CH_NUL) begin
                    semi_stop = 1'b1;
                end else if (win_a[i] == ";") begin
                    tok_semi  = 4'(i);
                    semi_stop = 1'b1;
                end
            end
        end
    end

    // Classify the token at the window head
    logic       tok_num, tok_nl, tok_it, tok_pb, tok_hex;
    logic [1:0] tok_nch;
    byte_t      tok_c0, tok_c1;
    logic [3:0] tok_n, tok_sp, clen;
    logic [2:0] tok_ss;
    logic [1:0] sec_idx;
    logic       open_done, ent_done;
    always_comb begin
        tok_num   = 1'b0;
        tok_nl    = 1'b0;
        tok_nch   = 2'd0;
        tok_c0    = CH_NUL;
        tok_c1    = CH_NUL;
        tok_n     = 4'd1;
        tok_it    = inside_tag_reg;
        tok_pb    = prev_blank_reg;
        tok_ss    = skip_sec_reg;
        tok_sp    = skip_pos_reg;
        sec_idx   = 2'(skip_sec_reg - 3'd1);
        clen      = close_len(sec_idx);
        open_done = 1'b0;
        ent_done  = 1'b0;
        tok_hex   = (win_a[2] == "x") || (win_a[2] == "X");
        if (fill_reg == '0) begin
            tok_n = 4'd0;
        end else if (skip_sec_reg != SKIP_NONE) begin
            if (skip_pos_reg < clen &&
                win_l[0] == pat_char(close_pat(sec_idx), clen, skip_pos_reg)) begin
                tok_sp = skip_pos_reg + 4'd1;
            end else if (win_l[0] == "<") begin
                tok_sp = 4'd1;
            end else begin
                tok_sp = 4'd0;
            end
            if (tok_sp >= clen) begin
                tok_ss = SKIP_NONE;
                tok_sp = 4'd0;
            end
        end else begin
            for (int i = 0; i < NUM_OPENERS; i++) begin
                if (!open_done && pat_hit(win_l, open_pat(2'(i)), open_len(2'(i)))) begin
                    open_done = 1'b1;
                    tok_ss    = 3'(i + 1);
                    tok_sp    = 4'd0;
                    tok_n     = open_len(2'(i));
                end
            end
            if (!open_done) begin
                if (win_a[0] == "<") begin
                    tok_it = 1'b1;
                    if (win_l[1] == "p" && (win_l[2] == ">" || win_l[2] == CH_SP)) begin
                        tok_nl  = 1'b1;
                        tok_nch = 2'd2;
                        tok_c0  = CH_SP;
                        tok_c1  = CH_SP;
                    end else if ((win_l[1] == "b" && win_l[2] == "r") ||
                                 (win_l[1] == "/" && win_l[2] == "d" && win_l[3] == "i" &&
                                  win_l[4] == "v" && win_l[5] == ">")) begin
                        tok_nl = 1'b1;
                    end else if (win_l[1] == "h") begin
                        tok_nl = 1'b1;
                    end else if (win_l[1] == "l" && win_l[2] == "i" &&
                                 (win_l[3] == ">" || win_l[3] == CH_SP)) begin
                        tok_nl  = 1'b1;
                        tok_nch = 2'd2;
                        tok_c0  = CH_DASH;
                        tok_c1  = CH_SP;
                    end
                end else if (win_a[0] == ">") begin
                    tok_it = 1'b0;
                end else if (!inside_tag_reg) begin
                    if (win_a[0] == "&") begin
                        for (int i = 0; i < NUM_ENTS; i++) begin
                            if (!ent_done &&
                                pat_hit(win_l, ent_pat(4'(i)), ent_len(4'(i)))) begin
                                ent_done = 1'b1;
                                tok_nch  = 2'd1;
                                tok_c0   = ent_chr(4'(i));
                                tok_n    = ent_len(4'(i));
                            end
                        end
                        if (!ent_done && win_a[1] == "#" && tok_semi != 4'd0) begin
                            ent_done = 1'b1;
                            tok_num  = 1'b1;
                        end
                    end
                    if (!ent_done) begin
                        if (win_a[0] == CH_LF || win_a[0] == CH_CR) begin
                            tok_nl = 1'b1;
                        end else if (win_a[0] == CH_SP || win_a[0] == CH_TAB) begin
                            if (!prev_blank_reg) begin
                                tok_nch = 2'd1;
                                tok_c0  = CH_SP;
                                tok_pb  = 1'b1;
                            end
                        end else begin
                            tok_pb  = 1'b0;
                            tok_nch = 2'd1;
                            tok_c0  = win_a[0];
                        end
                    end
                end
            end
        end
    end

    // Numeric entity scan over the parse register head
    byte_t       p0, p1, p2;
    logic        p_ws, p_sign, p_pfx, dig_ok;
    logic [4:0]  hv0, hv2;
    logic [3:0]  dig_val;
    logic [20:0] acc_mul, acc_sum;
    byte_t       num_ch;
    always_comb begin
        p0      = prs_reg[0];
        p1      = prs_reg[1];
        p2      = prs_reg[2];
        hv0     = hex_val(p0);
        hv2     = hex_val(p2);
        p_ws    = (p0 == CH_SP) || (p0 >= 8'd9 && p0 <= 8'd13);
        p_sign  = (p0 == "+") || (p0 == "-");
        p_pfx   = hex_reg && p0 == "0" && lower8(p1) == "x" && hv2[4];
        dig_ok  = hex_reg ? hv0[4] : (p0 >= "0" && p0 <= "9");
        dig_val = hex_reg ? hv0[3:0] : 4'(p0 - 8'h30);
        acc_mul = hex_reg ? {1'b0, acc_reg, 4'b0000}
                          : ({2'b00, acc_reg, 3'b000} + {4'b0000, acc_reg, 1'b0});
        acc_sum = acc_mul + 21'(dig_val);
        if (big_reg || (neg_reg && acc_reg != 16'd0)) begin
            num_ch = CH_QMARK;
        end else if (acc_reg == 16'h201C || acc_reg == 16'h201D) begin
            num_ch = CH_DQUOTE;
        end else if (acc_reg == 16'h2018 || acc_reg == 16'h2019) begin
            num_ch = CH_SQUOTE;
        end else if (acc_reg == 16'h2014 || acc_reg == 16'h2013) begin
            num_ch = CH_DASH;
        end else if (acc_reg == 16'd160) begin
            num_ch = CH_SP;
        end else if (acc_reg < 16'd128) begin
            num_ch = acc_reg[7:0];
        end else begin
            num_ch = CH_QMARK;
        end
    end

    // Consume amount and what stays in the window
    logic              end_in, wr_ok;
    logic [FILL_W-1:0] fill_aft, cons_rem;
    logic [3:0]        cons_n;
    win_t              win_cons;
    always_comb begin
        end_in   = (s_in_byte == CH_NUL) || s_in_last;
        wr_ok    = (s_in_byte != CH_NUL) && (fill_reg < FILL_W'(WINDOW_BYTES));
        fill_aft = fill_reg + FILL_W'(wr_ok);
        cons_n   = (state_reg == F_N_DIG) ? (semi_reg + 4'd1) : tok_n;
        cons_rem = (FILL_W'(cons_n) >= fill_reg) ? '0 : (fill_reg - FILL_W'(cons_n));
        win_cons = win_reg >> {cons_n, 3'b000};
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid && !finished_reg &&
                    (end_in || fill_aft == FILL_W'(WINDOW_BYTES))) begin
                    state_next = F_TOKEN;
                end
            end
            F_TOKEN: begin
                if (tok_num) begin
                    state_next = F_N_WS;
                end else if (!q_full) begin
                    state_next = (flush_reg && cons_rem != '0) ? F_TOKEN : F_IDLE;
                end
            end
            F_N_WS: begin
                if (!p_ws) state_next = F_N_SIGN;
            end
            F_N_SIGN: state_next = F_N_PFX;
            F_N_PFX:  state_next = F_N_DIG;
            F_N_DIG: begin
                if (!dig_ok && !q_full) begin
                    state_next = (flush_reg && cons_rem != '0) ? F_TOKEN : F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_ready         = (state_reg == F_IDLE);
        q_push          = 1'b0;
        q_data          = '0;
        q_data.step_end = !flush_reg || cons_rem == '0;
        q_data.doc_end  = flush_reg && cons_rem == '0;
        win_next        = win_reg;
        fill_next       = fill_reg;
        inside_tag_next = inside_tag_reg;
        prev_blank_next = prev_blank_reg;
        skip_sec_next   = skip_sec_reg;
        skip_pos_next   = skip_pos_reg;
        finished_next   = finished_reg;
        flush_next      = flush_reg;
        prs_next        = prs_reg;
        hex_next        = hex_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        big_next        = big_reg;
        semi_next       = semi_reg;
        case (state_reg)
            F_IDLE: begin
                // Store the byte; ignore everything after the end
                if (s_valid && !finished_reg) begin
                    if (wr_ok) begin
                        win_next[fill_reg[WIN_IDX_W-1:0]] = s_in_byte;
                        fill_next = fill_aft;
                    end
                    flush_next = end_in;
                end
            end
            F_TOKEN: begin
                if (tok_num) begin
                    // Load the digits after the entity prefix
                    for (int j = 0; j < PRS_BYTES; j++) begin
                        prs_next[j] = tok_hex ? win_a[j + 3] : win_a[j + 2];
                    end
                    hex_next  = tok_hex;
                    neg_next  = 1'b0;
                    acc_next  = 16'd0;
                    big_next  = 1'b0;
                    semi_next = tok_semi;
                end else if (!q_full) begin
                    q_push          = 1'b1;
                    q_data.nl       = tok_nl;
                    q_data.n_chars  = tok_nch;
                    q_data.c0       = tok_c0;
                    q_data.c1       = tok_c1;
                    inside_tag_next = tok_it;
                    prev_blank_next = tok_pb;
                    skip_sec_next   = tok_ss;
                    skip_pos_next   = tok_sp;
                    win_next        = win_cons;
                    fill_next       = cons_rem;
                end
            end
            F_N_WS: begin
                if (p_ws) prs_next = prs_t'(prs_reg >> 8);
            end
            F_N_SIGN: begin
                if (p_sign) begin
                    neg_next = (p0 == "-");
                    prs_next = prs_t'(prs_reg >> 8);
                end
            end
            F_N_PFX: begin
                if (p_pfx) prs_next = prs_t'(prs_reg >> 16);
            end
            F_N_DIG: begin
                if (dig_ok) begin
                    acc_next = acc_sum[15:0];
                    big_next = big_reg || (acc_sum > 21'h00FFFF);
                    prs_next = prs_t'(prs_reg >> 8);
                end else if (!q_full) begin
                    q_push         = 1'b1;
                    q_data.n_chars = 2'd1;
                    q_data.c0      = num_ch;
                    win_next       = win_cons;
                    fill_next      = cons_rem;
                end
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
        // Close the document on its final token
        if (q_push && q_data.doc_end) begin
            finished_next = 1'b1;
            flush_next    = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            fill_reg       <= '0;
            inside_tag_reg <= 1'b0;
            prev_blank_reg <= 1'b0;
            skip_sec_reg   <= SKIP_NONE;
            skip_pos_reg   <= 4'd0;
            finished_reg   <= 1'b0;
            flush_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            inside_tag_reg <= inside_tag_next;
            prev_blank_reg <= prev_blank_next;
            skip_sec_reg   <= skip_sec_next;
            skip_pos_reg   <= skip_pos_next;
            finished_reg   <= finished_next;
            flush_reg      <= flush_next;
        end
    end

    // Window and parse payload
    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        prs_reg  <= prs_next;
        hex_reg  <= hex_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        big_reg  <= big_next;
        semi_reg <= semi_next;
    end

endmodule
`default_nettype wire

// ===== rtl/htf_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module htf_queue import htf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  din,
    output logic full,
    input  logic pop,
    output op_t  dout,
    output logic empty
);

    op_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Pointer and fill tracking
    always_comb begin
        full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
        empty       = (count_reg == '0);
        dout        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a request
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= din;
    end

    `HTF_ASSERT(a_q_bound, aclk, aresetn, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
    `HTF_ASSERT(a_q_no_ovf, aclk, aresetn, push |-> !full, "push into a full queue")
    `HTF_ASSERT(a_q_no_udf, aclk, aresetn, pop |-> !empty, "pop from an empty queue")
    `HTF_ASSERT_NR(a_q_rst, aclk, !aresetn |=> count_reg == '0, "queue not cleared by reset")

endmodule
`default_nettype wire

// ===== rtl/htf_back.sv =====
`default_nettype none
module htf_back import htf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        q_empty,
    input  op_t         q_data,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_out_valid,
    output logic        m_run_last,
    output logic        m_text_end
);

    back_phase_t ph_reg, ph_next;
    logic [15:0] max_len_reg;
    logic [15:0] raw_count_reg, raw_count_next;
    logic        prn_reg, prn_next;
    logic        pen_reg, pen_next;
    logic        held_vld_reg, held_vld_next;
    byte_t       held_chr_reg, held_chr_next;
    logic        m_valid_reg, m_valid_next;
    byte_t       out_char_reg, out_char_next;
    logic        out_vld_reg, out_vld_next;
    logic        run_last_reg, run_last_next;
    logic        text_end_reg, text_end_next;

    logic        go, nx_pop;
    back_phase_t nx_ph;

    // Advance only when a request waits and the output slot is free
    always_comb begin
        go = !q_empty && (!m_valid_reg || m_ready);
    end

    // Following phase of the current request
    always_comb begin
        nx_ph  = PH_END;
        nx_pop = 1'b0;
        case (ph_reg)
            PH_NL: begin
                if (q_data.n_chars != 2'd0) nx_ph = PH_C0;
                else if (!q_data.step_end) nx_pop = 1'b1;
            end
            PH_C0: begin
                if (q_data.n_chars == 2'd2) nx_ph = PH_C1;
                else if (!q_data.step_end) nx_pop = 1'b1;
            end
            PH_C1: begin
                if (!q_data.step_end) nx_pop = 1'b1;
            end
            PH_END:  nx_pop = 1'b1;
            default: nx_pop = 1'b1;
        endcase
    end

    // Next phase
    always_comb begin
        ph_next = ph_reg;
        if (go) ph_next = nx_pop ? PH_NL : nx_ph;
    end

    // Put characters against the limit and hold the last one of the step
    logic        put_en, emit, load;
    byte_t       put_c;
    logic [15:0] lim;
    always_comb begin
        q_pop          = go && nx_pop;
        lim            = (max_len_reg == 16'd0) ? 16'd0 : (max_len_reg - 16'd1);
        put_en         = 1'b0;
        put_c          = CH_LF;
        emit           = 1'b0;
        load           = 1'b0;
        raw_count_next = raw_count_reg;
        prn_next       = prn_reg;
        pen_next       = pen_reg;
        held_vld_next  = held_vld_reg;
        held_chr_next  = held_chr_reg;
        out_char_next  = out_char_reg;
        out_vld_next   = out_vld_reg;
        run_last_next  = run_last_reg;
        text_end_next  = text_end_reg;
        case (ph_reg)
            PH_NL: begin
                put_en = q_data.nl && raw_count_reg != 16'd0 && !prn_reg;
                put_c  = CH_LF;
            end
            PH_C0: begin
                put_en = 1'b1;
                put_c  = q_data.c0;
            end
            PH_C1: begin
                put_en = 1'b1;
                put_c  = q_data.c1;
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
        if (go) begin
            if (put_en && raw_count_reg < lim) begin
                raw_count_next = raw_count_reg + 16'd1;
                prn_next       = (put_c == CH_LF);
                if (put_c == CH_NUL) begin
                    raw_count_next = 16'hFFFF;
                end else if (!(put_c == CH_LF && pen_reg)) begin
                    pen_next = (put_c == CH_LF);
                    emit     = 1'b1;
                end
            end
            if (emit) begin
                if (held_vld_reg) begin
                    load          = 1'b1;
                    out_char_next = held_chr_reg;
                    out_vld_next  = 1'b1;
                    run_last_next = 1'b0;
                    text_end_next = 1'b0;
                end
                held_vld_next = 1'b1;
                held_chr_next = put_c;
            end
            if (ph_reg == PH_END) begin
                if (held_vld_reg) begin
                    load          = 1'b1;
                    out_char_next = held_chr_reg;
                    out_vld_next  = 1'b1;
                    run_last_next = 1'b1;
                    text_end_next = q_data.doc_end;
                    held_vld_next = 1'b0;
                end else if (q_data.doc_end) begin
                    load          = 1'b1;
                    out_char_next = CH_NUL;
                    out_vld_next  = 1'b0;
                    run_last_next = 1'b1;
                    text_end_next = 1'b1;
                end
            end
        end
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_comb begin
        m_valid     = m_valid_reg;
        m_out_char  = out_char_reg;
        m_out_valid = out_vld_reg;
        m_run_last  = run_last_reg;
        m_text_end  = text_end_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg        <= PH_NL;
            max_len_reg   <= MAX_LEN_RESET;
            raw_count_reg <= 16'd0;
            prn_reg       <= 1'b0;
            pen_reg       <= 1'b0;
            held_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            ph_reg        <= ph_next;
            raw_count_reg <= raw_count_next;
            prn_reg       <= prn_next;
            pen_reg       <= pen_next;
            held_vld_reg  <= held_vld_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) max_len_reg <= cfg_wr_data;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        held_chr_reg <= held_chr_next;
        out_char_reg <= out_char_next;
        out_vld_reg  <= out_vld_next;
        run_last_reg <= run_last_next;
        text_end_reg <= text_end_next;
    end

endmodule
`default_nettype wire

// ===== rtl/html_to_plain_text_filter_top.sv =====
// Channel  Handshake          Payload
// s_       s_valid/s_ready    s_in_byte[7:0], s_in_last
// m_       m_valid/m_ready    m_out_char[7:0], m_out_valid, m_run_last, m_text_end
// cfg_     cfg_wr_en          cfg_wr_data[15:0] (max_len, no wait)
//
// While the window fills, the front only stores each byte; once it is full, it
// stores the byte and then decodes the window head before it takes the next one.
// A numeric entity adds the blank, sign, prefix and digit states, which skip the
// leading blanks and read the digits. The back steps through the newline, character
// and end phases of each token; stalls on m_ready hold the back while the front
// keeps decoding into a 4-deep request queue. The end flush decodes one token per
// cycle, numeric entities aside, while the queue has room, until the window is empty.
// aresetn is synchronous; max_len returns to 8192 and the document state clears.
`default_nettype none
module html_to_plain_text_filter_top import htf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_out_valid,
    output logic        m_run_last,
    output logic        m_text_end,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic q_push, q_full, q_pop, q_empty;
    op_t  q_din, q_dout;

    // Decode tokens
    htf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_push    (q_push),
        .q_data    (q_din),
        .q_full    (q_full)
    );

    // Buffer requests
    htf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    // Produce characters
    htf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_data      (q_dout),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_out_valid (m_out_valid),
        .m_run_last  (m_run_last),
        .m_text_end  (m_text_end)
    );

endmodule
`default_nettype wire

// ===== tb/html_to_plain_text_filter_top_tb.sv =====
`timescale 1ns / 100ps
module html_to_plain_text_filter_top_tb;
    import htf_pkg::*;

    // One plain-text result as seen on the m_ channel
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       run_last;
        logic       text_end;
    } text_res_t;

    // Expected plain text, worked out byte by byte from the HTML stream
    class text_scoreboard;
        logic [15:0] limit;
        byte_t       win[WINDOW_BYTES];
        int          fill;
        bit          in_tag, blank_seen, raw_nl, out_nl, done;
        logic [15:0] raw_cnt;
        int          skip_kind;
        int          skip_pos;
        text_res_t   step_q[$];
        text_res_t   want_q[$];
        int          errors;
        int          n_checked;
        string       open_tag[4];
        string       shut_tag[4];
        string       ent_name[13];
        byte_t       ent_char[13];

        function new();
            limit = MAX_LEN_RESET;
            fill = 0; in_tag = 0; blank_seen = 0; raw_nl = 0; out_nl = 0; done = 0;
            raw_cnt = 0; skip_kind = SKIP_NONE; skip_pos = 0; errors = 0; n_checked = 0;
            open_tag = '{"<head", "<style", "<script", "<svg"};
            shut_tag = '{"</head>", "</style>", "</script>", "</svg>"};
            ent_name = '{"&quot;", "&apos;", "&lsquo;", "&rsquo;", "&ldquo;", "&rdquo;",
                         "&mdash;", "&ndash;", "&hellip;", "&amp;", "&lt;", "&gt;", "&nbsp;"};
            ent_char = '{CH_DQUOTE, CH_SQUOTE, CH_SQUOTE, CH_SQUOTE, CH_DQUOTE, CH_DQUOTE,
                         CH_DASH, CH_DASH, ".", "&", "<", ">", CH_SP};
        endfunction

        function void set_limit(logic [15:0] v);
            limit = v;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function byte_t fold(byte_t c);
            return (c >= "A" && c <= "Z") ? byte_t'(c + 8'd32) : c;
        endfunction

        function int hex_digit(byte_t c);
            byte_t lc;
            lc = fold(c);
            if (c >= "0" && c <= "9") return c - "0";
            if (lc >= "a" && lc <= "f") return lc - "a" + 10;
            return -1;
        endfunction

        // Bytes past the filled part of the window read as zero
        function byte_t peek(int i);
            return (i < fill && i < WINDOW_BYTES) ? win[i] : CH_NUL;
        endfunction

        function bit head_is(string p);
            for (int i = 0; i < p.len(); i++)
                if (fold(peek(i)) != p[i]) return 0;
            return 1;
        endfunction

        function void drop(int n);
            if (n >= fill) begin
                fill = 0;
                return;
            end
            for (int i = 0; i < fill - n; i++) win[i] = win[i + n];
            fill = fill - n;
        endfunction

        function void emit(byte_t c, bit v);
            text_res_t r;
            if (step_q.size() >= 48) return;
            r.ch = c; r.valid = v; r.run_last = 0; r.text_end = 0;
            step_q.push_back(r);
        endfunction

        // Count one character against the limit; fold repeated newlines
        function void put_char(byte_t c);
            logic [15:0] lim;
            lim = (limit != 0) ? limit - 16'd1 : 16'd0;
            if (raw_cnt >= lim) return;
            raw_cnt++;
            raw_nl = (c == CH_LF);
            if (c == CH_NUL) begin
                raw_cnt = 16'hFFFF;
                return;
            end
            if (c == CH_LF && out_nl) return;
            out_nl = (c == CH_LF);
            emit(c, 1);
        endfunction

        function void break_line();
            if (raw_cnt > 0 && !raw_nl) put_char(CH_LF);
        endfunction

        function bit decode_numeric();
            int          semi, k, d;
            bit          hex, neg;
            logic [31:0] acc;
            byte_t       c, ch;
            semi = 0; neg = 0; acc = 0;
            if (peek(1) != "#") return 0;
            for (int i = 1; i < 10; i++) begin
                c = peek(i);
                if (c == CH_NUL) break;
                if (c == ";") begin
                    semi = i;
                    break;
                end
            end
            if (semi == 0) return 0;
            hex = (peek(2) == "x" || peek(2) == "X");
            k = hex ? 3 : 2;
            while (peek(k) == CH_SP || (peek(k) >= 9 && peek(k) <= 13)) k++;
            if (peek(k) == "+" || peek(k) == "-") begin
                neg = (peek(k) == "-");
                k++;
            end
            if (hex && peek(k) == "0" && fold(peek(k + 1)) == "x" && hex_digit(peek(k + 2)) >= 0)
                k += 2;
            forever begin
                if (hex) d = hex_digit(peek(k));
                else d = (peek(k) >= "0" && peek(k) <= "9") ? peek(k) - "0" : -1;
                if (d < 0) break;
                if (acc >= 32'h1000_0000) acc = 32'hFFFF_FFFF;
                else acc = acc * (hex ? 16 : 10) + d;
                k++;
            end
            if (neg && acc != 0) ch = CH_QMARK;
            else if (acc == 32'h201C || acc == 32'h201D) ch = CH_DQUOTE;
            else if (acc == 32'h2018 || acc == 32'h2019) ch = CH_SQUOTE;
            else if (acc == 32'h2014 || acc == 32'h2013) ch = CH_DASH;
            else if (acc == 160) ch = CH_SP;
            else if (acc < 128) ch = acc[7:0];
            else ch = CH_QMARK;
            put_char(ch);
            drop(semi + 1);
            return 1;
        endfunction

        // Decode one token at the window head
        function void decode_head();
            byte_t c, lc;
            string t;
            c = peek(0);
            if (skip_kind != SKIP_NONE) begin
                t = shut_tag[skip_kind - 1];
                lc = fold(c);
                if (skip_pos < t.len() && lc == t[skip_pos]) skip_pos++;
                else skip_pos = (lc == "<") ? 1 : 0;
                if (skip_pos >= t.len()) begin
                    skip_kind = SKIP_NONE;
                    skip_pos = 0;
                end
                drop(1);
                return;
            end
            for (int i = 0; i < 4; i++) begin
                if (head_is(open_tag[i])) begin
                    skip_kind = i + 1;
                    skip_pos = 0;
                    drop(open_tag[i].len());
                    return;
                end
            end
            if (c == "<") begin
                in_tag = 1;
                if (head_is("<p>") || head_is("<p ")) begin
                    break_line(); put_char(CH_SP); put_char(CH_SP);
                end else if (head_is("<br") || head_is("</div>") || fold(peek(1)) == "h") begin
                    break_line();
                end else if (head_is("<li>") || head_is("<li ")) begin
                    break_line(); put_char(CH_DASH); put_char(CH_SP);
                end
                drop(1);
                return;
            end
            if (c == ">") begin
                in_tag = 0;
                drop(1);
                return;
            end
            if (in_tag) begin
                drop(1);
                return;
            end
            if (c == "&") begin
                for (int i = 0; i < 13; i++) begin
                    if (head_is(ent_name[i])) begin
                        put_char(ent_char[i]);
                        drop(ent_name[i].len());
                        return;
                    end
                end
                if (decode_numeric()) return;
            end
            if (c == CH_LF || c == CH_CR) begin
                break_line();
                drop(1);
                return;
            end
            if (c == CH_SP || c == CH_TAB) begin
                if (!blank_seen) begin
                    put_char(CH_SP);
                    blank_seen = 1;
                end
                drop(1);
                return;
            end
            blank_seen = 0;
            put_char(c);
            drop(1);
        endfunction

        // Note an accepted request and queue the text it produces
        function void note_byte(byte_t b, bit last);
            bit doc_end;
            doc_end = (b == CH_NUL) || last;
            if (done) return;
            step_q.delete();
            if (b != CH_NUL && fill < WINDOW_BYTES) begin
                win[fill] = b;
                fill++;
            end
            if (doc_end) begin
                while (fill > 0) decode_head();
                done = 1;
                if (step_q.size() == 0) emit(CH_NUL, 0);
                step_q[step_q.size() - 1].text_end = 1;
            end else if (fill >= WINDOW_BYTES) begin
                decode_head();
            end
            if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1;
            foreach (step_q[i]) want_q.push_back(step_q[i]);
        endfunction

        function void check_char(text_res_t got);
            text_res_t exp;
            if (want_q.size() == 0) begin
                $error("unexpected result: char %0h valid %0b", got.ch, got.valid);
                errors++;
                return;
            end
            exp = want_q.pop_front();
            n_checked++;
            if (got.ch !== exp.ch) begin
                $error("out_char: expected %0h, got %0h", exp.ch, got.ch);
                errors++;
            end
            if (got.valid !== exp.valid) begin
                $error("out_valid: expected %0b, got %0b", exp.valid, got.valid);
                errors++;
            end
            if (got.run_last !== exp.run_last) begin
                $error("run_last: expected %0b, got %0b", exp.run_last, got.run_last);
                errors++;
            end
            if (got.text_end !== exp.text_end) begin
                $error("text_end: expected %0b, got %0b", exp.text_end, got.text_end);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_in_last;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_char;
    logic        m_out_valid;
    logic        m_run_last;
    logic        m_text_end;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    text_scoreboard plain_sb;
    bit             idle_on;
    bit             hold_req;
    int             n_sent;
    int             stall_cnt;

    html_to_plain_text_filter_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_out_valid (m_out_valid),
        .m_run_last  (m_run_last),
        .m_text_end  (m_text_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            plain_sb.check_char({m_out_char, m_out_valid, m_run_last, m_text_end});
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt == STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_byte(byte_t b, bit last);
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        plain_sb.note_byte(b, last);
        n_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_byte(byte_t'(s[i]), 1'b0);
    endtask

    // Drain all expected text, let the front settle, then write max_len
    task automatic set_max_len(logic [15:0] v);
        s_valid <= 1'b0;
        while (plain_sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        plain_sb.set_limit(v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic string rand_word();
        string w;
        int    r;
        w = "";
        repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(0, 25);
            w = {w, string'($urandom_range(0, 1) ? byte'("A" + r) : byte'("a" + r))};
        end
        return w;
    endfunction

    function automatic int ent_value();
        case ($urandom_range(0, 9))
            0:       return 160;
            1:       return 'h201C;
            2:       return 'h201D;
            3:       return 'h2018;
            4:       return 'h2019;
            5:       return 'h2014;
            6:       return 'h2013;
            7:       return $urandom_range(128, 5000);
            default: return $urandom_range(1, 127);
        endcase
    endfunction

    // Send one random fragment of well-formed or broken HTML
    task automatic send_fragment();
        string tags[12];
        string names[6];
        string nm;
        tags  = '{"<p>", "<P class=a>", "<br/>", "</div>", "<h3>", "</H1>", "<li>",
                  "<LI id=q>", "<b>", "</span>", "<a href=x>", "<div>"};
        names = '{"head", "style", "script", "svg", "HEAD", "Style"};
        case ($urandom_range(0, 11))
            1: repeat ($urandom_range(1, 4)) send_text($urandom_range(0, 1) ? " " : "\t");
            2: send_text($urandom_range(0, 2) == 0 ? "\r\n" : ($urandom_range(0, 1) ? "\n" : "\r"));
            3: send_text(tags[$urandom_range(0, 11)]);
            4: send_text(plain_sb.ent_name[$urandom_range(0, 12)]);
            5: send_text($urandom_range(0, 3) == 0 ? $sformatf("&# +%0d;", ent_value())
                                                   : $sformatf("&#%0d;", ent_value()));
            6: send_text($urandom_range(0, 2) == 0 ? $sformatf("&#X0x%0h;", ent_value())
                                                   : $sformatf("&#x%0h;", ent_value()));
            7: begin
                nm = names[$urandom_range(0, 5)];
                send_text($sformatf("<%s>a<x</%s>", nm, nm));
            end
            8: repeat ($urandom_range(1, 3)) send_byte(byte_t'($urandom_range(1, 255)), 1'b0);
            9: case ($urandom_range(0, 5))
                0: send_text("&");
                1: send_text("<");
                2: send_text(">");
                3: send_text("&#;");
                4: send_text("&#-7;");
                default: send_text("&#9999999;");
            endcase
            default: send_text(rand_word());
        endcase
    endtask

    task automatic send_random(int n);
        int stop_at;
        stop_at = n_sent + n;
        while (n_sent < stop_at) send_fragment();
    endtask

    initial begin
        int hold_at;
        plain_sb    = new();
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_in_byte   <= 8'd0;
        s_in_last   <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 16'd0;
        idle_on     = 1;
        hold_req    = 0;
        n_sent      = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: tags, entities, blanks, line breaks, a closed section, byte extremes
        set_max_len(16'hFFFF);
        send_text("<P>A&amp;&#65;&#x2014;&#-3;&#200; \t\r\n<br><li>z</div><H2>&hellip;");
        send_text("<svg>q</SVG>");
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);

        // No room at all: zero, then one
        set_max_len(16'd0);
        send_random(20);
        set_max_len(16'd1);
        send_random(20);

        // Wide limit with a long receiver hold-off part way through
        set_max_len(16'($urandom_range(plain_sb.raw_cnt + 200, 65535)));
        hold_at = n_sent + 60;
        while (n_sent < hold_at) send_fragment();
        hold_req = 1;
        send_random(110);

        // Limit reached inside the last stretch, no idling
        set_max_len(plain_sb.raw_cnt + 16'd31);
        idle_on = 0;
        send_random(60);
        // Decoded NUL, then an unclosed section running to the end of the document
        send_text("x&#0;y <head>tail ");
        if ($urandom_range(0, 1)) send_byte(8'h00, 1'b0);
        else send_byte("z", 1'b1);
        // Requests after the end produce nothing
        repeat (4) send_byte(byte_t'($urandom_range(1, 255)), 1'b0);
        s_valid <= 1'b0;

        while (plain_sb.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d HTML requests, checked %0d results across five max_len settings,",
                 n_sent, plain_sb.n_checked);
        $display("with receiver stalls, one long hold-off and a quiet tail.");
        if (plain_sb.errors == 0 && plain_sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
